/* hw/rtl/box_non_max_suppression_top_assert.svh */
// Assertion macros for the box suppression block.
// Used by the top level only; needs clk and rst in scope.
`ifndef BOX_NON_MAX_SUPPRESSION_TOP_ASSERT_SVH
`define BOX_NON_MAX_SUPPRESSION_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BNMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BNMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/bnms_pkg.sv */
// Shared types and constants for the box suppression block.
// No dependencies.
package bnms_pkg;

  localparam int IDX_BITS     = 6;   // wide enough for the largest store
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IOU_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PER_CLASS     = 1'd1;

  localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;
  localparam logic        PER_CLASS_RESET     = 1'b1;

  typedef struct packed {
    logic [11:0] box_left;
    logic [11:0] box_top;
    logic [11:0] box_width;
    logic [11:0] box_height;
    logic [15:0] box_score;
    logic [6:0]  box_class;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [11:0] kept_left;
    logic [11:0] kept_top;
    logic [11:0] kept_width;
    logic [11:0] kept_height;
    logic [15:0] kept_score;
    logic [6:0]  kept_class;
    logic [5:0]  arrival_index;
    logic        last_kept;
    logic        overflowed;
  } out_item_t;

  typedef struct packed {
    logic                load_wr;
    logic                rank_rd;
    logic                rank_put;
    logic                rank_rd_a;
    logic                rank_rd_b;
    logic                box_rd_a;
    logic                box_rd_b;
    logic                test;
    logic                supp_clr;
    logic                out_load;
    logic                out_last;
    logic                out_overflow;
    logic [IDX_BITS-1:0] idx_a;
    logic [IDX_BITS-1:0] idx_b;
  } cmd_t;

  typedef struct packed {
    logic supp_a;
    logic supp_b;
  } status_t;

endpackage

/* hw/rtl/box_non_max_suppression_top.sv */
// Greedy IoU suppression: one box per item in, kept boxes out in score order.
// The set closes on its last item; ranking follows, then suppression of each later
// box by each kept one (a pair is skipped if the later box is gone), then emit.
// Throughput: one item per cycle while loading; a new set waits until the current
// set has drained.
// Reset (rst, synchronous): empty store, clear marks, default registers.
`include "box_non_max_suppression_top_assert.svh"

module box_non_max_suppression_top #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bnms_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bnms_pkg::out_item_t                 out_item,
  input  logic                                cfg_wr_en,
  input  logic [bnms_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bnms_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic [15:0]       iou_threshold;
  logic              per_class_mode;
  bnms_pkg::cmd_t    cmd;
  bnms_pkg::status_t status;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold  <= bnms_pkg::IOU_THRESHOLD_RESET;
      per_class_mode <= bnms_pkg::PER_CLASS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bnms_pkg::CFG_IOU_THRESHOLD: iou_threshold  <= cfg_data[15:0];
        bnms_pkg::CFG_PER_CLASS:     per_class_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: owns the load count, overflow flag and loop counters.
  bnms_controller #(
    .MAX_BOXES (MAX_BOXES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_is_last (in_item.is_last),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Stores, ranking, overlap arithmetic and the output item register.
  bnms_datapath #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .in_item        (in_item),
    .iou_threshold  (iou_threshold),
    .per_class_mode (per_class_mode),
    .status         (status),
    .out_item       (out_item)
  );

  // Hold off input while a kept box is on offer.
  `BNMS_ASSERT_NOW(a_no_load_while_emit, out_valid, !in_ready, "input taken during emit")
  // Store writes only on an accepted item.
  `BNMS_ASSERT_NOW(a_write_on_accept, cmd.load_wr, in_valid && in_ready, "store write without item")
  // A last item closes the set: stop accepting.
  `BNMS_ASSERT_NEXT(a_close_on_last, in_valid && in_ready && in_item.is_last, !in_ready,
                    "set not closed on last item")

endmodule

/* hw/rtl/bnms_datapath.sv */
// Datapath of the box suppression block: box stores, ranking counter,
// overlap pipeline, suppression marks and output register. Uses bnms_pkg.
module bnms_datapath #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  bnms_pkg::cmd_t     cmd,
  input  bnms_pkg::in_item_t in_item,
  input  logic [15:0]        iou_threshold,
  input  logic               per_class_mode,
  output bnms_pkg::status_t  status,
  output bnms_pkg::out_item_t out_item
);

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = COORD_BITS;
  localparam int AW = 2 * CW;
  localparam int PW = 2 * CW + 17;

  logic [4*CW-1:0] coord_mem [MAX_BOXES];
  logic [AW-1:0]   area_mem  [MAX_BOXES];
  logic [15:0]     score_mem [MAX_BOXES];
  logic [6:0]      class_mem [MAX_BOXES];
  logic [IW-1:0]   rank_mem  [MAX_BOXES];

  logic [4*CW-1:0] coord_a, coord_b;
  logic [AW-1:0]   area_a, area_b;
  logic [15:0]     score_a, score_b;
  logic [6:0]      class_a, class_b;
  logic [IW-1:0]   rank_q_a, rank_q_b;
  logic [IW-1:0]   rank_cnt;
  logic            step_d;
  logic [IW-1:0]   id_d, jd_d;
  logic [MAX_BOXES-1:0] supp;

  logic [CW-1:0]   in_w, in_h;
  logic [IW-1:0]   addr_a, addr_b, wr_addr;
  logic            rd_a, rd_b, beats;

  logic [CW-1:0]   la, ta, wa, ha, lb, tb, wb, hb;
  logic [CW:0]     xe_a, xe_b, ye_a, ye_b, x_hi, y_hi, x_lo, y_lo;
  logic [CW-1:0]   ox_c, oy_c, ox, oy;
  logic            match_c, match;
  logic [AW-1:0]   inter;
  logic [AW:0]     uni;
  logic [PW-1:0]   prod, lhs;
  logic            hit;

  assign in_w    = CW'(in_item.box_width);
  assign in_h    = CW'(in_item.box_height);
  assign wr_addr = cmd.idx_a[IW-1:0];
  assign addr_a  = cmd.rank_rd ? cmd.idx_a[IW-1:0] : rank_q_a;
  assign addr_b  = cmd.rank_rd ? cmd.idx_b[IW-1:0] : rank_q_b;
  assign rd_a    = cmd.rank_rd | cmd.box_rd_a;
  assign rd_b    = cmd.rank_rd | cmd.box_rd_b;

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      coord_mem[wr_addr] <= {CW'(in_item.box_left), CW'(in_item.box_top), in_w, in_h};
      area_mem[wr_addr]  <= AW'(in_w) * AW'(in_h);
      score_mem[wr_addr] <= in_item.box_score;
      class_mem[wr_addr] <= in_item.box_class;
    end
    if (rd_a) begin
      coord_a <= coord_mem[addr_a];
      area_a  <= area_mem[addr_a];
      score_a <= score_mem[addr_a];
      class_a <= class_mem[addr_a];
    end
    if (rd_b) begin
      coord_b <= coord_mem[addr_b];
      area_b  <= area_mem[addr_b];
      score_b <= score_mem[addr_b];
      class_b <= class_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rank_put) rank_mem[rank_cnt] <= cmd.idx_a[IW-1:0];
    if (cmd.rank_rd_a) rank_q_a <= rank_mem[cmd.idx_a[IW-1:0]];
    if (cmd.rank_rd_b) rank_q_b <= rank_mem[cmd.idx_b[IW-1:0]];
  end

  // Rank of a box: number of boxes with a higher score, or an equal score
  // and an earlier arrival.
  assign beats = (score_b > score_a) || ((score_b == score_a) && (jd_d < id_d));

  always_ff @(posedge clk) begin
    id_d <= cmd.idx_a[IW-1:0];
    jd_d <= cmd.idx_b[IW-1:0];
    if (rst) begin
      step_d   <= 1'b0;
      rank_cnt <= '0;
    end else begin
      step_d <= cmd.rank_rd;
      if (cmd.rank_put) rank_cnt <= '0;
      else if (step_d && beats) rank_cnt <= rank_cnt + 1'b1;
    end
  end

  // Overlap pipeline: spans, intersection, union, scaled threshold.
  assign {la, ta, wa, ha} = coord_a;
  assign {lb, tb, wb, hb} = coord_b;
  assign xe_a = {1'b0, la} + {1'b0, wa};
  assign xe_b = {1'b0, lb} + {1'b0, wb};
  assign ye_a = {1'b0, ta} + {1'b0, ha};
  assign ye_b = {1'b0, tb} + {1'b0, hb};
  assign x_lo = (la > lb) ? {1'b0, la} : {1'b0, lb};
  assign y_lo = (ta > tb) ? {1'b0, ta} : {1'b0, tb};
  assign x_hi = (xe_a < xe_b) ? xe_a : xe_b;
  assign y_hi = (ye_a < ye_b) ? ye_a : ye_b;
  assign ox_c = (x_hi > x_lo) ? CW'(x_hi - x_lo) : '0;
  assign oy_c = (y_hi > y_lo) ? CW'(y_hi - y_lo) : '0;
  assign match_c = !per_class_mode || (class_a == class_b);

  always_ff @(posedge clk) begin
    ox    <= ox_c;
    oy    <= oy_c;
    match <= match_c;
    inter <= AW'(ox) * AW'(oy);
    uni   <= (AW+1)'(area_a) + (AW+1)'(area_b) - (AW+1)'(inter);
    prod  <= PW'(iou_threshold) * PW'(uni);
    lhs   <= PW'({inter, 16'h0000});
  end

  assign hit = match && (lhs > prod);

  always_ff @(posedge clk) begin
    if (rst || cmd.supp_clr) supp <= '0;
    else if (cmd.test && hit) supp[rank_q_b] <= 1'b1;
  end

  assign status.supp_a = supp[rank_q_a];
  assign status.supp_b = supp[rank_q_b];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.kept_left     <= 12'(la);
      out_item.kept_top      <= 12'(ta);
      out_item.kept_width    <= 12'(wa);
      out_item.kept_height   <= 12'(ha);
      out_item.kept_score    <= score_a;
      out_item.kept_class    <= class_a;
      out_item.arrival_index <= 6'(rank_q_a);
      out_item.last_kept     <= cmd.out_last;
      out_item.overflowed    <= cmd.out_overflow;
    end
  end

endmodule

/* hw/rtl/bnms_controller.sv */
// Sequencer of the box suppression block: load, rank, suppress, emit.
// Drives the datapath through bnms_pkg command and status structs.
module bnms_controller #(
  parameter int MAX_BOXES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_is_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bnms_pkg::status_t status,
  output bnms_pkg::cmd_t    cmd
);

  localparam int IW = $clog2(MAX_BOXES);

  typedef enum logic [13:0] {
    ST_LOAD    = 14'b00000000000001,
    ST_R_ISSUE = 14'b00000000000010,
    ST_R_DRAIN = 14'b00000000000100,
    ST_R_PUT   = 14'b00000000001000,
    ST_A_RANK  = 14'b00000000010000,
    ST_A_BOX   = 14'b00000000100000,
    ST_B_RANK  = 14'b00000001000000,
    ST_B_BOX   = 14'b00000010000000,
    ST_B_CALC  = 14'b00000100000000,
    ST_B_TEST  = 14'b00001000000000,
    ST_E_RANK  = 14'b00010000000000,
    ST_E_BOX   = 14'b00100000000000,
    ST_E_LOAD  = 14'b01000000000000,
    ST_E_WAIT  = 14'b10000000000000
  } state_t;

  state_t        state, state_next;
  logic [IW:0]   count, count_next;
  logic          ovf, ovf_next;
  logic [IW-1:0] i, i_next, j, j_next, last_pos, last_pos_next;
  logic [1:0]    calc_cnt, calc_cnt_next;
  logic          out_valid_next;
  logic [IW-1:0] n_m1;

  assign n_m1 = IW'(count - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf       <= ovf_next;
      out_valid <= out_valid_next;
    end
    i        <= i_next;
    j        <= j_next;
    last_pos <= last_pos_next;
    calc_cnt <= calc_cnt_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ovf_next       = ovf;
    i_next         = i;
    j_next         = j;
    last_pos_next  = last_pos;
    calc_cnt_next  = calc_cnt;
    out_valid_next = out_valid;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.idx_a      = bnms_pkg::IDX_BITS'(i);
    cmd.idx_b      = bnms_pkg::IDX_BITS'(j);
    case (state)
      ST_LOAD: begin
        in_ready  = 1'b1;
        cmd.idx_a = bnms_pkg::IDX_BITS'(count[IW-1:0]);
        if (in_valid) begin
          if (count < (IW+1)'(MAX_BOXES)) begin
            cmd.load_wr = 1'b1;
            count_next  = count + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          if (in_is_last) begin
            i_next     = '0;
            j_next     = '0;
            state_next = ST_R_ISSUE;
          end
        end
      end
      ST_R_ISSUE: begin
        cmd.rank_rd = 1'b1;
        if (j == n_m1) state_next = ST_R_DRAIN;
        else j_next = j + 1'b1;
      end
      ST_R_DRAIN: state_next = ST_R_PUT;
      ST_R_PUT: begin
        cmd.rank_put = 1'b1;
        j_next = '0;
        if (i == n_m1) begin
          i_next     = '0;
          state_next = ST_A_RANK;
        end else begin
          i_next     = i + 1'b1;
          state_next = ST_R_ISSUE;
        end
      end
      ST_A_RANK: begin
        cmd.rank_rd_a = 1'b1;
        state_next    = ST_A_BOX;
      end
      ST_A_BOX: begin
        cmd.box_rd_a = 1'b1;
        if (!status.supp_a) last_pos_next = i;
        if (i == n_m1) begin
          i_next     = '0;
          state_next = ST_E_RANK;
        end else if (status.supp_a) begin
          i_next     = i + 1'b1;
          state_next = ST_A_RANK;
        end else begin
          j_next     = i + 1'b1;
          state_next = ST_B_RANK;
        end
      end
      ST_B_RANK: begin
        cmd.rank_rd_b = 1'b1;
        state_next    = ST_B_BOX;
      end
      ST_B_BOX: begin
        cmd.box_rd_b = 1'b1;
        if (status.supp_b) begin
          if (j == n_m1) begin
            i_next     = i + 1'b1;
            state_next = ST_A_RANK;
          end else begin
            j_next     = j + 1'b1;
            state_next = ST_B_RANK;
          end
        end else begin
          calc_cnt_next = '0;
          state_next    = ST_B_CALC;
        end
      end
      ST_B_CALC: begin
        calc_cnt_next = calc_cnt + 1'b1;
        if (calc_cnt == 2'd3) state_next = ST_B_TEST;
      end
      ST_B_TEST: begin
        cmd.test = 1'b1;
        if (j == n_m1) begin
          i_next     = i + 1'b1;
          state_next = ST_A_RANK;
        end else begin
          j_next     = j + 1'b1;
          state_next = ST_B_RANK;
        end
      end
      ST_E_RANK: begin
        cmd.rank_rd_a = 1'b1;
        state_next    = ST_E_BOX;
      end
      ST_E_BOX, ST_E_WAIT: begin
        if (state == ST_E_BOX) cmd.box_rd_a = 1'b1;
        if ((state == ST_E_BOX && status.supp_a) || (state == ST_E_WAIT && out_ready)) begin
          out_valid_next = 1'b0;
          if (i == n_m1) begin
            count_next   = '0;
            ovf_next     = 1'b0;
            cmd.supp_clr = 1'b1;
            state_next   = ST_LOAD;
          end else begin
            i_next     = i + 1'b1;
            state_next = ST_E_RANK;
          end
        end else if (state == ST_E_BOX) begin
          state_next = ST_E_LOAD;
        end
      end
      ST_E_LOAD: begin
        cmd.out_load     = 1'b1;
        cmd.out_last     = (i == last_pos);
        cmd.out_overflow = ovf;
        out_valid_next   = 1'b1;
        state_next       = ST_E_WAIT;
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

/* tb/box_non_max_suppression_top_test.sv */
// Self-checking bench for box_non_max_suppression_top: random box sets, greedy IoU prediction.
// Depends on bnms_pkg and the box_non_max_suppression_top RTL.
module box_non_max_suppression_top_test;

  localparam int CAPACITY    = 64;
  localparam int STALL_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  bnms_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bnms_pkg::out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [bnms_pkg::CFG_IDX_BITS-1:0] cfg_index = bnms_pkg::CFG_IOU_THRESHOLD;
  logic [bnms_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  box_non_max_suppression_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Stimulus queue, expected kept boxes, and the predictor's own copy of the set.
  bnms_pkg::in_item_t  pending_boxes[$];
  bnms_pkg::out_item_t kept_boxes[$];
  bnms_pkg::in_item_t  set_boxes[CAPACITY];
  int        set_count;
  bit        set_overflow;
  logic [15:0] pred_threshold;
  logic        pred_per_class;

  int  fail_count, kept_seen, boxes_sent, sets_closed;
  int  send_idle_pct, recv_stall_pct;
  bit  hold_off;
  int  hold_cycles;
  int  idle_cycles;

  // Acceptance seen at the rising edge, used by the driver on the falling edge.
  logic in_ready_seen = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic queue_box(bnms_pkg::in_item_t b);
    pending_boxes.insert(pending_boxes.size(), b);
  endtask

  function automatic logic [63:0] span_overlap(logic [11:0] a0, logic [11:0] alen,
                                               logic [11:0] b0, logic [11:0] blen);
    logic [12:0] a1, b1, lo, hi;
    a1 = a0 + alen;
    b1 = b0 + blen;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? 64'(hi - lo) : 64'd0;
  endfunction

  function automatic bit too_close(bnms_pkg::in_item_t p, bnms_pkg::in_item_t q);
    logic [63:0] inter, uni;
    inter = span_overlap(p.box_left, p.box_width, q.box_left, q.box_width) *
            span_overlap(p.box_top, p.box_height, q.box_top, q.box_height);
    uni = 64'(p.box_width) * 64'(p.box_height) + 64'(q.box_width) * 64'(q.box_height) - inter;
    return (inter << 16) > 64'(pred_threshold) * uni;
  endfunction

  // Load one box into the predicted set; on the last box rank, suppress and emit.
  task automatic predict_box(bnms_pkg::in_item_t b);
    int order[CAPACITY];
    bit gone[CAPACITY];
    int i, j, v, n;
    bnms_pkg::out_item_t r;
    if (set_count < CAPACITY) begin
      set_boxes[set_count] = b;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!b.is_last) return;
    for (i = 0; i < set_count; i++) begin
      v = i;
      j = i;
      while (j > 0 && set_boxes[order[j-1]].box_score < set_boxes[v].box_score) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
      gone[i] = 1'b0;
    end
    for (i = 0; i < set_count; i++) begin
      if (gone[order[i]]) continue;
      for (j = i + 1; j < set_count; j++) begin
        if (gone[order[j]]) continue;
        if (pred_per_class &&
            set_boxes[order[i]].box_class != set_boxes[order[j]].box_class) continue;
        if (too_close(set_boxes[order[i]], set_boxes[order[j]])) gone[order[j]] = 1'b1;
      end
    end
    n = 0;
    for (i = 0; i < set_count; i++) begin
      if (gone[order[i]]) continue;
      r.kept_left     = set_boxes[order[i]].box_left;
      r.kept_top      = set_boxes[order[i]].box_top;
      r.kept_width    = set_boxes[order[i]].box_width;
      r.kept_height   = set_boxes[order[i]].box_height;
      r.kept_score    = set_boxes[order[i]].box_score;
      r.kept_class    = set_boxes[order[i]].box_class;
      r.arrival_index = 6'(order[i]);
      r.last_kept     = 1'b0;
      r.overflowed    = set_overflow;
      kept_boxes.insert(kept_boxes.size(), r);
      n++;
    end
    if (n > 0) kept_boxes[kept_boxes.size()-1].last_kept = 1'b1;
    set_count = 0;
    set_overflow = 1'b0;
    sets_closed++;
  endtask

  // Driver: offer the next queued box, idling at the chosen rate.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_boxes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= pending_boxes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on accepted boxes, check kept boxes, run the watchdog.
  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_box(in_item);
        boxes_sent++;
      end
      if (out_valid && out_ready) begin
        kept_seen++;
        if (kept_boxes.size() == 0) begin
          report_mismatch("unexpected kept box", 64'(out_item.arrival_index), 64'd0);
        end else begin
          bnms_pkg::out_item_t w;
          w = kept_boxes.pop_front();
          if (out_item.kept_left != w.kept_left)
            report_mismatch("left", 64'(out_item.kept_left), 64'(w.kept_left));
          if (out_item.kept_top != w.kept_top)
            report_mismatch("top", 64'(out_item.kept_top), 64'(w.kept_top));
          if (out_item.kept_width != w.kept_width)
            report_mismatch("width", 64'(out_item.kept_width), 64'(w.kept_width));
          if (out_item.kept_height != w.kept_height)
            report_mismatch("height", 64'(out_item.kept_height), 64'(w.kept_height));
          if (out_item.kept_score != w.kept_score)
            report_mismatch("score", 64'(out_item.kept_score), 64'(w.kept_score));
          if (out_item.kept_class != w.kept_class)
            report_mismatch("class", 64'(out_item.kept_class), 64'(w.kept_class));
          if (out_item.arrival_index != w.arrival_index)
            report_mismatch("arrival index", 64'(out_item.arrival_index),
                            64'(w.arrival_index));
          if (out_item.last_kept != w.last_kept)
            report_mismatch("last kept", 64'(out_item.last_kept), 64'(w.last_kept));
          if (out_item.overflowed != w.overflowed)
            report_mismatch("overflow", 64'(out_item.overflowed), 64'(w.overflowed));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Long receiver hold-off, counted here so the block fills and stalls its input.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      if (hold_cycles == 1) hold_off <= 1'b0;
    end
  end

  function automatic bnms_pkg::in_item_t random_box(bit last, int cls_span, bit cluster,
                                                    bnms_pkg::in_item_t seed_box);
    bnms_pkg::in_item_t b;
    b = bnms_pkg::in_item_t'(72'({$urandom, $urandom, $urandom}));
    if (cluster) begin
      // jitter round a seed box so that overlaps are common
      b.box_left   = seed_box.box_left + 12'($urandom_range(40));
      b.box_top    = seed_box.box_top + 12'($urandom_range(40));
      b.box_width  = seed_box.box_width + 12'($urandom_range(40));
      b.box_height = seed_box.box_height + 12'($urandom_range(40));
    end else if ($urandom_range(3) != 0) begin
      b.box_width  = 12'($urandom_range(400));
      b.box_height = 12'($urandom_range(400));
    end
    if ($urandom_range(4) == 0) b.box_score = 16'($urandom_range(3)) << 14;
    b.box_class = ($urandom_range(5) == 0) ? 7'($urandom) : 7'($urandom_range(cls_span));
    b.is_last = last;
    return b;
  endfunction

  task automatic queue_set(int n);
    bnms_pkg::in_item_t seed_box;
    seed_box = random_box(1'b0, 3, 1'b0, '0);
    seed_box.box_width  = 12'($urandom_range(20, 300));
    seed_box.box_height = 12'($urandom_range(20, 300));
    for (int i = 0; i < n; i++)
      queue_box(random_box(i == n - 1, 3, $urandom_range(2) != 0, seed_box));
  endtask

  task automatic write_reg(logic [bnms_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [bnms_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == bnms_pkg::CFG_IOU_THRESHOLD) pred_threshold = val;
    else pred_per_class = val[0];
  endtask

  // Wait for every queued box and every kept box, then let the block settle.
  task automatic drain;
    wait (pending_boxes.size() == 0 && !in_valid && kept_boxes.size() == 0);
    repeat (CAPACITY * (CAPACITY + 2) + 200) @(posedge clk);
  endtask

  initial begin
    bnms_pkg::in_item_t b;
    pred_threshold = bnms_pkg::IOU_THRESHOLD_RESET;
    pred_per_class = bnms_pkg::PER_CLASS_RESET;
    set_count = 0;
    set_overflow = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    hold_cycles = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, a single box, identical boxes, zero area, ties.
    queue_box('{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 7'h7F, 1'b1});
    queue_box('{12'h0, 12'h0, 12'h0, 12'h0, 16'h0, 7'h0, 1'b0});
    queue_box('{12'h0, 12'h0, 12'h0, 12'h0, 16'h0, 7'h0, 1'b1});
    b = '{12'd10, 12'd10, 12'd100, 12'd100, 16'h8000, 7'd1, 1'b0};
    queue_box(b);
    queue_box(b);
    b.box_class = 7'd2;
    queue_box(b);
    b = '{12'd20, 12'd20, 12'd100, 12'd100, 16'h9000, 7'd1, 1'b0};
    queue_box(b);
    b = '{12'd500, 12'd500, 12'd50, 12'd50, 16'h9000, 7'd1, 1'b1};
    queue_box(b);
    drain();

    // Threshold extremes with class mode off.
    write_reg(bnms_pkg::CFG_IOU_THRESHOLD, 16'd0);
    write_reg(bnms_pkg::CFG_PER_CLASS, 16'd0);
    queue_set(6);
    drain();
    write_reg(bnms_pkg::CFG_IOU_THRESHOLD, 16'hFFFF);
    queue_set(6);
    drain();

    // Overflow: one more than capacity, the last box itself dropped.
    write_reg(bnms_pkg::CFG_IOU_THRESHOLD, 16'h4000);
    for (int i = 0; i <= CAPACITY; i++) begin
      b = random_box(i == CAPACITY, 3, 1'b0, '0);
      queue_box(b);
    end
    drain();

    // Random phases with different idling, settings changed in between.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(bnms_pkg::CFG_IOU_THRESHOLD, 16'($urandom));
      write_reg(bnms_pkg::CFG_PER_CLASS, 16'($urandom_range(1)));
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 50) : 0;
      recv_stall_pct = (ph == 2) ? 50 : ((ph == 3) ? 32 : 0);
      for (int k = 0; k < 8; k++) queue_set($urandom_range(1, 12));
      if (ph == 2) begin
        // hold the receiver off while further sets stream in
        hold_off = 1'b1;
        hold_cycles = 3000;
        for (int k = 0; k < 4; k++) queue_set($urandom_range(2, 8));
      end
      drain();
    end

    write_reg(bnms_pkg::CFG_IOU_THRESHOLD, bnms_pkg::IOU_THRESHOLD_RESET);
    write_reg(bnms_pkg::CFG_PER_CLASS, 16'd1);
    queue_set(40);
    drain();

    $display("covered %0d boxes in %0d sets, %0d kept boxes checked",
             boxes_sent, sets_closed, kept_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
